// ===== rtl/core/motion_axis_pid_shaper_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motion axis PID shaper
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef MOTION_AXIS_PID_SHAPER_DEFINES_SVH
`define MOTION_AXIS_PID_SHAPER_DEFINES_SVH

// Check that is switched off while reset is held.
`define MAPSH_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define MAPSH_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mapsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion axis PID shaper package
// Widths and status types shared by the sequencer and the serial multiplier.
// ----------------------------------------------------------------------------
package mapsh_pkg;

  // Coefficient operand, sample operand and full product widths.
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Status of the serial multiplier as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== rtl/core/mapsh_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Takes one bit of the B operand per cycle and adds the A operand into a
// narrow upper half, shifting the product right.
// ----------------------------------------------------------------------------
module mapsh_serial_mul import mapsh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod,
  output mul_stat_t                 stat
);

  logic signed [MUL_A_W-1:0] a_reg;
  logic signed [MUL_A_W:0]   hi;
  logic        [MUL_B_W-1:0] lo;
  logic        [MUL_CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic signed [MUL_A_W:0]   addend;
  logic signed [MUL_A_W:0]   sum;
  logic                      last_bit;

  // The top bit of B carries negative weight, so it subtracts A.
  always_comb begin
    last_bit = (cnt == MUL_CNT_W'(MUL_B_W - 1));
    if (!lo[0]) begin
      addend = '0;
    end else if (last_bit) begin
      addend = -(($bits(addend))'(a_reg));
    end else begin
      addend = ($bits(addend))'(a_reg);
    end
    sum = hi + addend;
  end

  // Shift-add sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        a_reg <= a;
        hi    <= '0;
        lo    <= b;
      end else if (busy) begin
        hi  <= {sum[MUL_A_W], sum[MUL_A_W:1]};
        lo  <= {sum[0], lo[MUL_B_W-1:1]};
        cnt <= cnt + 1'b1;
        if (last_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = MUL_P_W'({hi, lo});
  assign stat = '{busy: busy, done: done};

endmodule

// ===== rtl/core/motion_axis_pid_shaper.sv =====
// ----------------------------------------------------------------------------
// Motion axis PID shaper
// Gates items on elapsed time, updates a tracked value through PID or bypass
// with optional recovery, then shapes it with a quadratic, all on one serial multiplier.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_stall     elapsed_us, sample
//  out      out_valid / out_stall   shaped_value, tracked_value
//  cfg      cfg_write               cfg_index, cfg_data
//
// An item that does not pass the time gate only adds to the time accumulator and gives no result.
// An updating item runs 4 to 7 products on the one serial multiplier, each
// through S_START, S_MUL and S_POST; then the result waits in S_OUT for the output register.
// Reset is synchronous and restores configuration, axis state and out_valid to defaults.
// A stalled output holds its item; the next item may enter meanwhile.
// ----------------------------------------------------------------------------
module motion_axis_pid_shaper import mapsh_pkg::*; #(
  parameter int WRAP_LIMIT     = 12868,
  parameter int WRAP_RANGE     = 25736,
  parameter int RECOVER_TARGET = 0,
  parameter int UPDATE_GATE_US = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] elapsed_us,
  input  logic signed [15:0] sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] shaped_value,
  output logic signed [15:0] tracked_value,
  input  logic               cfg_write,
  input  logic         [2:0] cfg_index,
  input  logic        [23:0] cfg_data
);

`include "motion_axis_pid_shaper_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_START, S_MUL, S_POST, S_OUT} state_t;
  typedef enum logic [2:0] {OP_P, OP_D, OP_I, OP_BYP, OP_REC, OP_SQ, OP_A, OP_B} op_t;
  typedef enum logic [2:0] {
    R_MODE, R_GAIN_P, R_GAIN_I, R_GAIN_D, R_RECOVER, R_SHAPE_A, R_SHAPE_B, R_SHAPE_C
  } reg_idx_t;

  localparam logic signed [17:0] WL18   = 18'(WRAP_LIMIT);
  localparam logic signed [18:0] WR19   = 19'(WRAP_RANGE);
  localparam logic signed [16:0] TGT17  = 17'(RECOVER_TARGET);
  localparam logic        [19:0] GATE20 = 20'(UPDATE_GATE_US);
  localparam logic signed [63:0] PI_Q12 = 64'sd12868;

  // Configuration registers.
  logic              [1:0] mode_flags;
  logic signed      [23:0] gain_p, gain_i, gain_d, recover_gain;
  logic signed      [23:0] shape_a, shape_b, shape_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags   <= 2'd3;
      gain_p       <= 24'sd65536;
      gain_i       <= '0;
      gain_d       <= '0;
      recover_gain <= 24'sd655;
      shape_a      <= '0;
      shape_b      <= 24'sd65536;
      shape_c      <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        R_MODE:    mode_flags   <= cfg_data[1:0];
        R_GAIN_P:  gain_p       <= cfg_data;
        R_GAIN_I:  gain_i       <= cfg_data;
        R_GAIN_D:  gain_d       <= cfg_data;
        R_RECOVER: recover_gain <= cfg_data;
        R_SHAPE_A: shape_a      <= cfg_data;
        R_SHAPE_B: shape_b      <= cfg_data;
        R_SHAPE_C: shape_c      <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Axis state and working registers.
  state_t                  state;
  op_t                     op;
  logic             [19:0] time_acc;
  logic signed      [15:0] previous_sample;
  logic signed      [15:0] tracked;
  logic signed      [17:0] last_error;
  logic signed      [31:0] error_sum;
  logic signed      [17:0] diff_r;
  logic signed      [18:0] de_r;
  logic signed      [15:0] smp_r;
  logic signed      [31:0] xx_r;
  logic signed      [63:0] acc_r;
  logic signed      [15:0] shaped_r;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  mul_stat_t                 mul_stat;

  mapsh_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  // Time gate and wrapped step change, worked out as the item enters.
  logic             [20:0] acc_sum;
  logic             [19:0] acc_sat;
  logic                    gate_pass;
  logic signed      [16:0] d17;
  logic signed      [17:0] ad18;
  logic signed      [18:0] nd19;
  logic signed      [18:0] diff19;
  logic                    opposite;
  logic                    in_take;

  always_comb begin
    in_take   = in_valid && !in_stall;
    acc_sum   = {1'b0, time_acc} + 21'(elapsed_us);
    acc_sat   = acc_sum[20] ? 20'hFFFFF : acc_sum[19:0];
    gate_pass = acc_sat > GATE20;
    d17       = 17'(sample) - 17'(previous_sample);
    ad18      = d17[16] ? -18'(d17) : 18'(d17);
    opposite  = (sample[15] && previous_sample > 16'sd0) ||
                (sample > 16'sd0 && previous_sample[15]);
    nd19      = WR19 - 19'(ad18);
    if (ad18 > WL18 && opposite) begin
      diff19 = (sample > 16'sd0) ? -nd19 : nd19;
    end else begin
      diff19 = 19'(d17);
    end
  end

  // Operand selection for the product of the current step.
  always_comb begin
    mul_start = (state == S_START);
    unique case (op)
      OP_P:   begin mul_a = gain_p;       mul_b = 32'(diff_r); end
      OP_D:   begin mul_a = gain_d;       mul_b = 32'(de_r); end
      OP_I:   begin mul_a = gain_i;       mul_b = error_sum; end
      OP_BYP: begin mul_a = gain_p;       mul_b = 32'(17'(smp_r) - 17'(tracked)); end
      OP_REC: begin mul_a = recover_gain; mul_b = 32'(TGT17 - 17'(tracked)); end
      OP_SQ:  begin mul_a = 24'(tracked); mul_b = 32'(tracked); end
      OP_A:   begin mul_a = shape_a;      mul_b = xx_r; end
      OP_B:   begin mul_a = shape_b;      mul_b = 32'(tracked); end
      default: begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // Results of each finished product.
  logic signed [63:0] prod64;
  logic signed [63:0] step64;
  logic signed [63:0] pid_sum;
  logic signed [63:0] pid_t;
  logic signed [15:0] pid_tracked;
  logic signed [15:0] step_tracked;
  logic signed [32:0] es33;
  logic signed [31:0] es_next;
  logic signed [63:0] shape_sum;
  logic signed [15:0] shaped_next;
  op_t                after_track;

  always_comb begin
    prod64       = 64'(mul_prod);
    step64       = 64'(tracked) + ((prod64 + 64'sd32768) >>> 16);
    step_tracked = sat16(step64);
    pid_sum      = acc_r + prod64;
    pid_t        = 64'(tracked) + ((pid_sum + 64'sd32768) >>> 16);
    if (pid_t > PI_Q12) begin
      pid_tracked = 16'(PI_Q12);
    end else if (pid_t < -PI_Q12) begin
      pid_tracked = 16'(-PI_Q12);
    end else begin
      pid_tracked = 16'(pid_t);
    end
    es33 = 33'(error_sum) + 33'(diff_r);
    if (es33 > 33'sh07FFFFFFF) begin
      es_next = 32'sh7FFFFFFF;
    end else if (es33 < -33'sh080000000) begin
      es_next = 32'sh80000000;
    end else begin
      es_next = 32'(es33);
    end
    shape_sum   = acc_r + (prod64 <<< 12);
    shaped_next = sat16((shape_sum + 64'sd134217728) >>> 28);
    after_track = mode_flags[1] ? OP_REC : OP_SQ;
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer, axis state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      op              <= OP_P;
      time_acc        <= '0;
      previous_sample <= '0;
      tracked         <= '0;
      last_error      <= '0;
      error_sum       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (gate_pass) begin
              time_acc        <= '0;
              previous_sample <= sample;
              smp_r           <= sample;
              diff_r          <= 18'(diff19);
              de_r            <= 19'(diff19) - 19'(last_error);
              op              <= mode_flags[0] ? OP_P : OP_BYP;
              state           <= S_START;
            end else begin
              time_acc <= acc_sat;
            end
          end
        end
        S_START: state <= S_MUL;
        S_MUL: begin
          if (mul_stat.done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          unique case (op)
            OP_P: begin
              acc_r <= prod64;
              op    <= OP_D;
              state <= S_START;
            end
            OP_D: begin
              acc_r <= pid_sum;
              op    <= OP_I;
              state <= S_START;
            end
            OP_I: begin
              tracked    <= pid_tracked;
              last_error <= diff_r;
              error_sum  <= es_next;
              op         <= after_track;
              state      <= S_START;
            end
            OP_BYP: begin
              tracked <= step_tracked;
              op      <= after_track;
              state   <= S_START;
            end
            OP_REC: begin
              tracked <= step_tracked;
              op      <= OP_SQ;
              state   <= S_START;
            end
            OP_SQ: begin
              xx_r  <= 32'(mul_prod);
              op    <= OP_A;
              state <= S_START;
            end
            OP_A: begin
              acc_r <= prod64 + (64'(shape_c) <<< 24);
              op    <= OP_B;
              state <= S_START;
            end
            OP_B: begin
              shaped_r <= shaped_next;
              state    <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            shaped_value  <= shaped_r;
            tracked_value <= tracked;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The multiplier only finishes while the sequencer waits for it.
  `MAPSH_CHECK(a_done_in_mul, mul_stat.done |-> state == S_MUL, "product finished out of step")
  // An item under the time gate leaves the sequencer idle.
  `MAPSH_CHECK(a_gate_idle, (in_take && !gate_pass) |=> state == S_IDLE, "gated item started work")
  // A result placed in a free output register is shown on the next cycle.
  `MAPSH_CHECK(a_out_load, (state == S_OUT && (!out_valid || !out_stall)) |=> out_valid,
               "result lost at output")
  // The multiplier is never restarted while it is busy.
  `MAPSH_CHECK_ALWAYS(a_no_restart, rst || !(mul_start && mul_stat.busy), "multiplier restarted")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the motion axis PID shaper
// Drives timed samples through several register settings, predicts each
// update of the tracked and shaped values, and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int WRAP_LIMIT     = 12868;
  localparam int WRAP_RANGE     = 25736;
  localparam int RECOVER_TARGET = 0;
  localparam int UPDATE_GATE_US = 1000;
  localparam int PI_Q12         = 12868;
  localparam int ACC_MAX        = 1048575;
  localparam int SETTLE_CYCLES  = 400;

  // Register indexes.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_GAIN_P  = 3'd1;
  localparam logic [2:0] REG_GAIN_I  = 3'd2;
  localparam logic [2:0] REG_GAIN_D  = 3'd3;
  localparam logic [2:0] REG_RECOVER = 3'd4;
  localparam logic [2:0] REG_SHAPE_A = 3'd5;
  localparam logic [2:0] REG_SHAPE_B = 3'd6;
  localparam logic [2:0] REG_SHAPE_C = 3'd7;

  localparam logic [1:0] MODE_PID     = 2'b01;
  localparam logic [1:0] MODE_RECOVER = 2'b10;

  typedef struct packed {
    logic [15:0]        elapsed;
    logic signed [15:0] smp;
  } axis_item_t;

  typedef struct packed {
    logic signed [15:0] shaped;
    logic signed [15:0] trk;
  } axis_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] elapsed_us = '0;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] shaped_value;
  logic signed [15:0] tracked_value;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  motion_axis_pid_shaper DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .elapsed_us(elapsed_us), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .shaped_value(shaped_value), .tracked_value(tracked_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and register copy.
  logic [23:0]  shadow_regs [8];
  int unsigned  pred_accum;
  longint       pred_prev;
  longint       pred_tracked;
  longint       pred_last_err;
  longint       pred_err_sum;

  axis_item_t   pending_items [$];
  axis_result_t expected_results [$];
  int           mismatch_count = 0;
  int           sent_count = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint coeff(int i);
    return longint'($signed(shadow_regs[i]));
  endfunction

  // Works out the result of one accepted item, if the time gate opens.
  task automatic predict_axis_update(axis_item_t it);
    longint s, t, d, ad, diff, mv, acc;
    axis_result_t r;
    s = longint'(it.smp);
    pred_accum = pred_accum + it.elapsed;
    if (pred_accum > ACC_MAX) pred_accum = ACC_MAX;
    if (pred_accum <= UPDATE_GATE_US) return;
    t = pred_tracked;
    if ((shadow_regs[REG_MODE][1:0] & MODE_PID) != 2'b00) begin
      d = s - pred_prev;
      ad = d < 0 ? -d : d;
      diff = d;
      if (ad > WRAP_LIMIT && s * pred_prev < 0)
        diff = s > 0 ? -(WRAP_RANGE - ad) : (WRAP_RANGE - ad);
      diff = clip(diff, -131072, 131071);
      mv = coeff(REG_GAIN_P) * diff + coeff(REG_GAIN_D) * (diff - pred_last_err)
           + coeff(REG_GAIN_I) * pred_err_sum;
      mv = round_q(mv, 16);
      pred_last_err = diff;
      pred_err_sum = clip(pred_err_sum + diff, -64'sd2147483648, 64'sd2147483647);
      t = clip(t + mv, -PI_Q12, PI_Q12);
    end else begin
      t = clip(t + round_q(coeff(REG_GAIN_P) * (s - t), 16), -32768, 32767);
    end
    pred_prev = s;
    if ((shadow_regs[REG_MODE][1:0] & MODE_RECOVER) != 2'b00)
      t = clip(t + round_q(coeff(REG_RECOVER) * (RECOVER_TARGET - t), 16),
               -32768, 32767);
    pred_tracked = t;
    acc = t * t * coeff(REG_SHAPE_A) + t * coeff(REG_SHAPE_B) * 4096
          + coeff(REG_SHAPE_C) * 16777216;
    acc = clip(round_q(acc, 28), -32768, 32767);
    pred_accum = 0;
    r.shaped = acc[15:0];
    r.trk = t[15:0];
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: bursts of items separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_axis_update('{elapsed: elapsed_us, smp: sample});
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          axis_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          elapsed_us <= it.elapsed;
          sample <= it.smp;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver stall pattern and result checking.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", shaped_value, 0);
        end else begin
          axis_result_t e;
          e = expected_results.pop_front();
          if (shaped_value !== e.shaped) report_mismatch("shaped_value", shaped_value, e.shaped);
          if (tracked_value !== e.trk) report_mismatch("tracked_value", tracked_value, e.trk);
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    shadow_regs[idx] = (idx == REG_MODE) ? {22'd0, val[1:0]} : val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elapsed();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($urandom_range(0, 1100));
    if (k < 9) return 16'($urandom_range(900, 2000));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_sample();
    int k;
    k = $urandom_range(0, 7);
    if (k < 3) return 16'($urandom_range(0, 2 * PI_Q12) - PI_Q12);
    if (k == 3) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] rand_gain();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return 24'h7FFFFF;
    if (k == 1) return 24'h800000;
    if (k < 4) return 24'($urandom_range(0, 131072) - 65536);
    return 24'($urandom);
  endfunction

  // Stimulus: directed items, then random phases over changing registers.
  initial begin
    shadow_regs = '{24'd3, 24'd65536, 24'd0, 24'd0, 24'd655, 24'd0, 24'd65536, 24'd0};
    pred_accum = 0; pred_prev = 0; pred_tracked = 0; pred_last_err = 0; pred_err_sum = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Gate edge, extremes, repeated samples and wrap crossings.
    pending_items.push_back('{16'd1000, 16'sd100});
    pending_items.push_back('{16'd1, 16'sd200});
    pending_items.push_back('{16'd500, 16'sd0});
    pending_items.push_back('{16'd501, -16'sd12000});
    pending_items.push_back('{16'd2000, 16'sd12000});
    pending_items.push_back('{16'd2000, -16'sd12000});
    pending_items.push_back('{16'hFFFF, 16'sh7FFF});
    pending_items.push_back('{16'hFFFF, -16'sh8000});
    pending_items.push_back('{16'd1001, 16'sd0});
    for (int i = 0; i < 20; i++) pending_items.push_back('{16'hFFFF, 16'sd5});
    pending_items.push_back('{16'd2000, 16'sd12868});
    pending_items.push_back('{16'd2000, -16'sd1});
    wait_idle();

    write_reg(REG_MODE, 24'd0);
    write_reg(REG_GAIN_P, 24'h7FFFFF);
    write_reg(REG_SHAPE_A, 24'h7FFFFF);
    write_reg(REG_SHAPE_C, 24'h800000);
    pending_items.push_back('{16'd2000, 16'sh7FFF});
    pending_items.push_back('{16'd2000, -16'sh8000});
    pending_items.push_back('{16'd2000, 16'sd0});
    wait_idle();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(REG_MODE, 24'($urandom_range(0, 3)));
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, ($urandom_range(0, 2) == 0) ? rand_gain() : 24'd0);
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_RECOVER, rand_gain());
      write_reg(REG_SHAPE_A, rand_gain());
      write_reg(REG_SHAPE_B, rand_gain());
      write_reg(REG_SHAPE_C, rand_gain());
      for (int i = 0; i < 150; i++) pending_items.push_back('{rand_elapsed(), rand_sample()});
      wait_idle();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[motion_axis_pid_shaper] OK");
    end else begin
      $display("[motion_axis_pid_shaper] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[motion_axis_pid_shaper] ERROR");
    $finish;
  end

endmodule
